// ----- hdl/cmcs_pkg.sv -----
package cmcs_pkg;

   localparam int unsigned MaxResidues = 1024;
   localparam int unsigned IdxWidth    = 10;
   localparam int unsigned CoordWidth  = 18;
   localparam int unsigned PosWidth    = 3 * CoordWidth;
   localparam int unsigned DiffWidth   = CoordWidth + 1;
   localparam int unsigned SqWidth     = 2 * DiffWidth;
   localparam int unsigned RootWidth   = SqWidth / 2;
   localparam int unsigned RemWidth    = RootWidth + 3;
   localparam int unsigned DistWidth   = 19;
   localparam int unsigned ProbWidth   = 9;
   localparam int unsigned WeightWidth = 10;
   localparam int unsigned PenWidth    = DistWidth + WeightWidth;
   localparam int unsigned ScoreWidth  = 48;
   localparam int unsigned SepWidth    = 10;

   localparam logic [SepWidth-1:0]   MinSepReset = 10'd6;
   localparam logic [DistWidth-1:0]  EightQ6     = 19'd512;
   localparam logic [SqWidth-1:0]    EightSqQ12  = 38'd262144;
   localparam logic [ProbWidth-1:0]  HalfQ8      = 9'd128;
   localparam logic [ScoreWidth-1:0] ScoreMax    = {ScoreWidth{1'b1}};

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_PAIR  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQ,
      S_SQRT,
      S_PEN,
      S_ACC,
      S_DONE
   } state_type;

endpackage

// ----- hdl/contact_map_constraint_scorer.sv -----
// Flow: load, clear and unused items go from S_IDLE to S_DONE and the result register;
//   pair items first pass x, y, z squaring, the square root, penalty and accumulate.
// Throughput: one item at a time; a pair is paced by the bit-serial square-root
//   loop, and every item waits in S_DONE while the result register is stalled.
// Reset: synchronous, active high; clears score, min_separation to 6 and
//   control; the position memory is undefined until loaded.
module contact_map_constraint_scorer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [cmcs_pkg::SepWidth-1:0]         csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_op,
   input  logic [cmcs_pkg::IdxWidth-1:0]         req_residue_index,
   input  logic [cmcs_pkg::IdxWidth-1:0]         req_other_index,
   input  logic                                  req_is_glycine,
   input  logic signed [cmcs_pkg::CoordWidth-1:0] req_ca_x,
   input  logic signed [cmcs_pkg::CoordWidth-1:0] req_ca_y,
   input  logic signed [cmcs_pkg::CoordWidth-1:0] req_ca_z,
   input  logic signed [cmcs_pkg::CoordWidth-1:0] req_cb_x,
   input  logic signed [cmcs_pkg::CoordWidth-1:0] req_cb_y,
   input  logic signed [cmcs_pkg::CoordWidth-1:0] req_cb_z,
   input  logic [cmcs_pkg::ProbWidth-1:0]        req_contact_prob,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cmcs_pkg::DistWidth-1:0]        rsp_pair_distance,
   output logic                                  rsp_in_contact,
   output logic                                  rsp_pair_counted,
   output logic                                  rsp_mismatch,
   output logic [cmcs_pkg::ScoreWidth-1:0]       rsp_running_score
);

   localparam int unsigned CW = cmcs_pkg::CoordWidth;

   // Position store: {x, y, z} per residue, two registered read ports.
   logic [cmcs_pkg::PosWidth-1:0] pos_mem [0:cmcs_pkg::MaxResidues-1];
   logic [cmcs_pkg::PosWidth-1:0] rd_a_ff, rd_b_ff;

   cmcs_pkg::state_type state_ff, state_in;
   logic [cmcs_pkg::SepWidth-1:0]   min_sep_ff;
   logic [cmcs_pkg::ScoreWidth-1:0] score_ff, score_in;
   logic [1:0]                      sq_cnt_ff, sq_cnt_in;
   logic [4:0]                      it_cnt_ff, it_cnt_in;
   logic [cmcs_pkg::SqWidth-1:0]    sq_ff, sq_in;
   logic [cmcs_pkg::SqWidth-1:0]    rad_ff, rad_in;
   logic [cmcs_pkg::RemWidth-1:0]   rem_ff, rem_in;
   logic [cmcs_pkg::RootWidth-1:0]  root_ff, root_in;
   logic                            counted_ff, counted_in;
   logic                            cons_ff, cons_in;
   logic                            pair_ff, pair_in;
   logic [cmcs_pkg::WeightWidth-1:0] weight_ff, weight_in;
   logic                            contact_ff, contact_in;
   logic                            mis_ff, mis_in;
   logic [cmcs_pkg::PenWidth-1:0]   pen_ff, pen_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cmcs_pkg::DistWidth-1:0]  rsp_dist_ff;
   logic                            rsp_contact_ff, rsp_counted_ff, rsp_mis_ff;
   logic [cmcs_pkg::ScoreWidth-1:0] rsp_score_ff;

   logic                            accept;
   cmcs_pkg::op_type                op;
   logic signed [CW-1:0]            comp_a, comp_b;
   logic signed [cmcs_pkg::DiffWidth-1:0] diff;
   logic signed [cmcs_pkg::SqWidth-1:0]   diff_sq;
   logic [cmcs_pkg::RemWidth-1:0]   rem_sh, trial;
   logic [cmcs_pkg::DistWidth-1:0]  dist_q6, dd;
   logic [cmcs_pkg::ScoreWidth:0]   score_sum;
   logic [cmcs_pkg::SepWidth:0]     sep;
   logic                            out_free;

   assign op        = cmcs_pkg::op_type'(req_op);
   assign req_stall = (state_ff != cmcs_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dist_q6   = cmcs_pkg::DistWidth'(root_ff);
   assign sep       = {1'b0, req_other_index} - {1'b0, req_residue_index};

   // Memory: write on load beat, read both residues on every accepted beat.
   always_ff @(posedge clock) begin
      if (accept && op == cmcs_pkg::OP_LOAD) begin
         if (req_is_glycine) begin
            pos_mem[req_residue_index] <= {req_ca_x, req_ca_y, req_ca_z};
         end else begin
            pos_mem[req_residue_index] <= {req_cb_x, req_cb_y, req_cb_z};
         end
      end
      // Hold the read data for the whole item; the request may move on.
      if (accept) begin
         rd_a_ff <= pos_mem[req_residue_index];
         rd_b_ff <= pos_mem[req_other_index];
      end
   end

   // Select one coordinate per squaring cycle: x, then y, then z.
   always_comb begin
      unique case (sq_cnt_ff)
         2'd0:    begin comp_a = rd_a_ff[3*CW-1:2*CW]; comp_b = rd_b_ff[3*CW-1:2*CW]; end
         2'd1:    begin comp_a = rd_a_ff[2*CW-1:CW];   comp_b = rd_b_ff[2*CW-1:CW];   end
         default: begin comp_a = rd_a_ff[CW-1:0];      comp_b = rd_b_ff[CW-1:0];      end
      endcase
      diff    = cmcs_pkg::DiffWidth'(comp_a) - cmcs_pkg::DiffWidth'(comp_b);
      diff_sq = diff * diff;
   end

   // One root bit per cycle, restoring form.
   assign rem_sh = {rem_ff[cmcs_pkg::RemWidth-3:0], rad_ff[cmcs_pkg::SqWidth-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign dd     = (dist_q6 >= cmcs_pkg::EightQ6) ? dist_q6 - cmcs_pkg::EightQ6
                                                  : cmcs_pkg::EightQ6 - dist_q6;
   assign score_sum = {1'b0, score_ff} + (cmcs_pkg::ScoreWidth + 1)'(pen_ff);

   always_comb begin
      state_in     = state_ff;
      score_in     = score_ff;
      sq_cnt_in    = sq_cnt_ff;
      it_cnt_in    = it_cnt_ff;
      sq_in        = sq_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      counted_in   = counted_ff;
      cons_in      = cons_ff;
      pair_in      = pair_ff;
      weight_in    = weight_ff;
      contact_in   = contact_ff;
      mis_in       = mis_ff;
      pen_in       = pen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         cmcs_pkg::S_IDLE: begin
            if (accept) begin
               // Capture the pair's side terms; other ops report zeros.
               pair_in    = (op == cmcs_pkg::OP_PAIR);
               counted_in = !sep[cmcs_pkg::SepWidth] &&
                            (sep[cmcs_pkg::SepWidth-1:0] >= min_sep_ff);
               cons_in    = (req_contact_prob > cmcs_pkg::HalfQ8);
               weight_in  = cmcs_pkg::WeightWidth'(cmcs_pkg::HalfQ8) +
                            cmcs_pkg::WeightWidth'((req_contact_prob >= cmcs_pkg::HalfQ8)
                               ? req_contact_prob - cmcs_pkg::HalfQ8
                               : cmcs_pkg::HalfQ8 - req_contact_prob);
               root_in    = '0;
               contact_in = 1'b0;
               mis_in     = 1'b0;
               sq_in      = '0;
               sq_cnt_in  = '0;
               if (op == cmcs_pkg::OP_CLEAR) begin
                  score_in = '0;
               end
               state_in = (op == cmcs_pkg::OP_PAIR) ? cmcs_pkg::S_SQ : cmcs_pkg::S_DONE;
            end
         end
         cmcs_pkg::S_SQ: begin
            sq_in     = sq_ff + $unsigned(diff_sq);
            sq_cnt_in = sq_cnt_ff + 2'd1;
            if (sq_cnt_ff == 2'd2) begin
               rad_in    = sq_ff + $unsigned(diff_sq);
               rem_in    = '0;
               root_in   = '0;
               it_cnt_in = '0;
               state_in  = cmcs_pkg::S_SQRT;
            end
         end
         cmcs_pkg::S_SQRT: begin
            rad_in    = {rad_ff[cmcs_pkg::SqWidth-3:0], 2'b00};
            it_cnt_in = it_cnt_ff + 5'd1;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[cmcs_pkg::RootWidth-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[cmcs_pkg::RootWidth-2:0], 1'b0};
            end
            if (it_cnt_ff == 5'(cmcs_pkg::RootWidth - 1)) begin
               state_in = cmcs_pkg::S_PEN;
            end
         end
         cmcs_pkg::S_PEN: begin
            contact_in = (sq_ff <= cmcs_pkg::EightSqQ12);
            mis_in     = counted_ff && (cons_ff != (sq_ff <= cmcs_pkg::EightSqQ12));
            pen_in     = dd * weight_ff;
            state_in   = cmcs_pkg::S_ACC;
         end
         cmcs_pkg::S_ACC: begin
            // Saturate at the top of the score range.
            if (mis_ff) begin
               if (score_sum >= {1'b0, cmcs_pkg::ScoreMax}) begin
                  score_in = cmcs_pkg::ScoreMax;
               end else begin
                  score_in = score_sum[cmcs_pkg::ScoreWidth-1:0];
               end
            end
            state_in = cmcs_pkg::S_DONE;
         end
         cmcs_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = cmcs_pkg::S_IDLE;
            end
         end
         default: state_in = cmcs_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmcs_pkg::S_IDLE;
         score_ff     <= '0;
         min_sep_ff   <= cmcs_pkg::MinSepReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         score_ff     <= score_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_sep_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_cnt_ff  <= sq_cnt_in;
      it_cnt_ff  <= it_cnt_in;
      sq_ff      <= sq_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      counted_ff <= counted_in;
      cons_ff    <= cons_in;
      pair_ff    <= pair_in;
      weight_ff  <= weight_in;
      contact_ff <= contact_in;
      mis_ff     <= mis_in;
      pen_ff     <= pen_in;
      // Load the result beat when the output register frees up.
      if (state_ff == cmcs_pkg::S_DONE && out_free) begin
         rsp_dist_ff    <= pair_ff ? dist_q6 : '0;
         rsp_contact_ff <= pair_ff && contact_ff;
         rsp_counted_ff <= pair_ff && counted_ff;
         rsp_mis_ff     <= pair_ff && mis_ff;
         rsp_score_ff   <= score_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pair_distance = rsp_dist_ff;
   assign rsp_in_contact    = rsp_contact_ff;
   assign rsp_pair_counted  = rsp_counted_ff;
   assign rsp_mismatch      = rsp_mis_ff;
   assign rsp_running_score = rsp_score_ff;

   a_mis_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_mismatch || rsp_pair_counted))
      else $error("mismatch on uncounted pair");

   a_contact_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_contact) |-> (rsp_pair_distance <= cmcs_pkg::EightQ6))
      else $error("contact beyond 8 A");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == cmcs_pkg::S_DONE))
      else $error("result beat without finished item");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One request beat as presented on the req_ channel.
   typedef struct {
      cmcs_pkg::op_type                       op;
      logic [cmcs_pkg::IdxWidth-1:0]          res_i;
      logic [cmcs_pkg::IdxWidth-1:0]          res_j;
      logic                                   glycine;
      logic signed [cmcs_pkg::CoordWidth-1:0] ca [3];
      logic signed [cmcs_pkg::CoordWidth-1:0] cb [3];
      logic [cmcs_pkg::ProbWidth-1:0]         prob;
   } pair_req_type;

   // One result beat as seen on the rsp_ channel.
   typedef struct {
      logic [cmcs_pkg::DistWidth-1:0]  dist_q6;
      logic                            contact;
      logic                            counted;
      logic                            mis;
      logic [cmcs_pkg::ScoreWidth-1:0] score;
   } score_beat_type;

   // Scoreboard: shadow copy of the residue store, score and separation,
   // plus the queue of predicted result beats.
   class scoreboard_type;
      logic signed [cmcs_pkg::CoordWidth-1:0] pos_x [cmcs_pkg::MaxResidues];
      logic signed [cmcs_pkg::CoordWidth-1:0] pos_y [cmcs_pkg::MaxResidues];
      logic signed [cmcs_pkg::CoordWidth-1:0] pos_z [cmcs_pkg::MaxResidues];
      longint unsigned score_acc;
      logic [cmcs_pkg::SepWidth-1:0] min_sep;
      score_beat_type expected_beats [$];
      int errors;
      int results_seen;
      int pairs_scored;
      int penalties_seen;

      function new();
         score_acc = 0;
         min_sep = cmcs_pkg::MinSepReset;
         errors = 0;
         results_seen = 0;
         pairs_scored = 0;
         penalties_seen = 0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // Floor square root by binary search on the result.
      function longint unsigned floor_root(longint unsigned sq);
         longint unsigned lo;
         longint unsigned hi;
         longint unsigned mid;
         lo = 0;
         hi = 64'd1 << 20;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= sq) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      // Note an accepted request beat and predict its result.
      function void note_request(pair_req_type it);
         score_beat_type b;
         longint signed dx, dy, dz;
         longint unsigned sq, root, dd, pw, pen;
         longint signed sep_diff;
         logic want_contact;
         b.dist_q6 = '0;
         b.contact = 1'b0;
         b.counted = 1'b0;
         b.mis = 1'b0;
         case (it.op)
            cmcs_pkg::OP_LOAD: begin
               if (it.glycine) begin
                  pos_x[it.res_i] = it.ca[0];
                  pos_y[it.res_i] = it.ca[1];
                  pos_z[it.res_i] = it.ca[2];
               end else begin
                  pos_x[it.res_i] = it.cb[0];
                  pos_y[it.res_i] = it.cb[1];
                  pos_z[it.res_i] = it.cb[2];
               end
            end
            cmcs_pkg::OP_PAIR: begin
               pairs_scored++;
               dx = longint'(pos_x[it.res_i]) - longint'(pos_x[it.res_j]);
               dy = longint'(pos_y[it.res_i]) - longint'(pos_y[it.res_j]);
               dz = longint'(pos_z[it.res_i]) - longint'(pos_z[it.res_j]);
               sq = dx * dx + dy * dy + dz * dz;
               root = floor_root(sq);
               if (root > 524287) root = 524287;
               b.dist_q6 = root[cmcs_pkg::DistWidth-1:0];
               b.contact = (sq <= 64'd262144);
               sep_diff = longint'(it.res_j) - longint'(it.res_i);
               b.counted = (sep_diff >= longint'(min_sep));
               want_contact = (it.prob > cmcs_pkg::HalfQ8);
               if (b.counted && (want_contact != b.contact)) begin
                  b.mis = 1'b1;
                  penalties_seen++;
                  dd = (root >= 512) ? root - 512 : 512 - root;
                  pw = 128 + ((it.prob >= cmcs_pkg::HalfQ8) ? it.prob - 128
                                                            : 128 - it.prob);
                  pen = dd * pw;
                  if (pen >= cmcs_pkg::ScoreMax - score_acc) score_acc = cmcs_pkg::ScoreMax;
                  else score_acc = score_acc + pen;
               end
            end
            cmcs_pkg::OP_CLEAR: score_acc = 0;
            default: ;
         endcase
         b.score = score_acc[cmcs_pkg::ScoreWidth-1:0];
         expected_beats.push_back(b);
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      // Compare an accepted result beat with the oldest prediction.
      task check_result(score_beat_type got);
         score_beat_type want;
         results_seen++;
         if (expected_beats.size() == 0) begin
            report("result beat with no request outstanding");
         end else begin
            want = expected_beats.pop_front();
            if (got.dist_q6 !== want.dist_q6)
               report($sformatf("pair_distance %0d, expected %0d",
                                got.dist_q6, want.dist_q6));
            if (got.contact !== want.contact)
               report($sformatf("in_contact %0b, expected %0b", got.contact, want.contact));
            if (got.counted !== want.counted)
               report($sformatf("pair_counted %0b, expected %0b", got.counted, want.counted));
            if (got.mis !== want.mis)
               report($sformatf("mismatch %0b, expected %0b", got.mis, want.mis));
            if (got.score !== want.score)
               report($sformatf("running_score %0d, expected %0d", got.score, want.score));
         end
      endtask
   endclass

   localparam int WatchdogLimit = 3000;
   localparam int HoldOffCycles = 400;
   localparam int DrainCycles   = 40;

   logic                                   clock;
   logic                                   reset;
   logic                                   csr_wr_en;
   logic [cmcs_pkg::SepWidth-1:0]          csr_wr_data;
   logic                                   req_valid;
   logic                                   req_stall;
   logic [1:0]                             req_op;
   logic [cmcs_pkg::IdxWidth-1:0]          req_residue_index;
   logic [cmcs_pkg::IdxWidth-1:0]          req_other_index;
   logic                                   req_is_glycine;
   logic signed [cmcs_pkg::CoordWidth-1:0] req_ca_x, req_ca_y, req_ca_z;
   logic signed [cmcs_pkg::CoordWidth-1:0] req_cb_x, req_cb_y, req_cb_z;
   logic [cmcs_pkg::ProbWidth-1:0]         req_contact_prob;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic [cmcs_pkg::DistWidth-1:0]         rsp_pair_distance;
   logic                                   rsp_in_contact;
   logic                                   rsp_pair_counted;
   logic                                   rsp_mismatch;
   logic [cmcs_pkg::ScoreWidth-1:0]        rsp_running_score;

   scoreboard_type sb;
   pair_req_type on_wire;       // the beat currently presented
   int   req_beats;             // accepted request beats, advanced by the monitor
   int   idle_pct;              // sender idle chance per cycle
   int   stall_pct;             // receiver stall chance per cycle
   int   hold_left;             // long receiver hold-off still to run
   int   hold_asked;            // long hold-offs asked for by the stimulus
   int   hold_done;             // long hold-offs started by the receiver
   int   quiet_cycles;
   bit   loaded [cmcs_pkg::MaxResidues];  // residues with a defined stored position
   int   loaded_list [$];
   int   sep_settings;

   contact_map_constraint_scorer i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_residue_index (req_residue_index),
      .req_other_index   (req_other_index),
      .req_is_glycine    (req_is_glycine),
      .req_ca_x          (req_ca_x),
      .req_ca_y          (req_ca_y),
      .req_ca_z          (req_ca_z),
      .req_cb_x          (req_cb_x),
      .req_cb_y          (req_cb_y),
      .req_cb_z          (req_cb_z),
      .req_contact_prob  (req_contact_prob),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pair_distance (rsp_pair_distance),
      .rsp_in_contact    (rsp_in_contact),
      .rsp_pair_counted  (rsp_pair_counted),
      .rsp_mismatch      (rsp_mismatch),
      .rsp_running_score (rsp_running_score)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Monitor: sample both channels at the rising edge. Inputs only move on
   // the falling edge, so the sampled values are settled.
   always @(posedge clock) begin
      score_beat_type got;
      if (reset) begin
         req_beats = 0;
      end else begin
         if (req_valid && !req_stall) begin
            sb.note_request(on_wire);
            req_beats++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.dist_q6 = rsp_pair_distance;
            got.contact = rsp_in_contact;
            got.counted = rsp_pair_counted;
            got.mis     = rsp_mismatch;
            got.score   = rsp_running_score;
            sb.check_result(got);
         end
      end
   end

   // Receiver: random stall per cycle, or one long hold-off when asked, so the
   // block fills up and has to stall its input while the sender keeps going.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
         hold_left = 0;
         hold_done = 0;
      end else if (hold_asked != hold_done && hold_left == 0) begin
         hold_done = hold_asked;
         hold_left = HoldOffCycles - 1;
         rsp_stall = 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Timeout: no beat for %0d cycles", WatchdogLimit);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [cmcs_pkg::CoordWidth-1:0] rand_coord(bit wide);
      if (wide) return $signed(cmcs_pkg::CoordWidth'($urandom()));
      return $signed(cmcs_pkg::CoordWidth'($urandom_range(0, 1600))) - 18'sd800;
   endfunction

   // Load beat: the representative atom gets (x,y,z), the other one noise.
   function automatic pair_req_type make_load(int idx, bit gly,
                                              logic signed [cmcs_pkg::CoordWidth-1:0] x,
                                              logic signed [cmcs_pkg::CoordWidth-1:0] y,
                                              logic signed [cmcs_pkg::CoordWidth-1:0] z);
      pair_req_type it;
      it.op = cmcs_pkg::OP_LOAD;
      it.res_i = cmcs_pkg::IdxWidth'(idx);
      it.res_j = cmcs_pkg::IdxWidth'($urandom());
      it.glycine = gly;
      it.prob = cmcs_pkg::ProbWidth'($urandom());
      for (int k = 0; k < 3; k++) begin
         it.ca[k] = $signed(cmcs_pkg::CoordWidth'($urandom()));
         it.cb[k] = $signed(cmcs_pkg::CoordWidth'($urandom()));
      end
      if (gly) begin
         it.ca[0] = x; it.ca[1] = y; it.ca[2] = z;
      end else begin
         it.cb[0] = x; it.cb[1] = y; it.cb[2] = z;
      end
      return it;
   endfunction

   function automatic pair_req_type make_other(cmcs_pkg::op_type op, int i, int j,
                                               logic [cmcs_pkg::ProbWidth-1:0] p);
      pair_req_type it;
      it.op = op;
      it.res_i = cmcs_pkg::IdxWidth'(i);
      it.res_j = cmcs_pkg::IdxWidth'(j);
      it.glycine = 1'($urandom());
      it.prob = p;
      for (int k = 0; k < 3; k++) begin
         it.ca[k] = $signed(cmcs_pkg::CoordWidth'($urandom()));
         it.cb[k] = $signed(cmcs_pkg::CoordWidth'($urandom()));
      end
      return it;
   endfunction

   // Present one beat at the falling edge and hold it until accepted.
   task automatic send(pair_req_type it);
      int seen;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      on_wire = it;
      req_op = it.op;
      req_residue_index = it.res_i;
      req_other_index = it.res_j;
      req_is_glycine = it.glycine;
      req_ca_x = it.ca[0]; req_ca_y = it.ca[1]; req_ca_z = it.ca[2];
      req_cb_x = it.cb[0]; req_cb_y = it.cb[1]; req_cb_z = it.cb[2];
      req_contact_prob = it.prob;
      req_valid = 1'b1;
      seen = req_beats;
      do @(negedge clock); while (req_beats == seen);
      if (it.op == cmcs_pkg::OP_LOAD && !loaded[it.res_i]) begin
         loaded[it.res_i] = 1'b1;
         loaded_list.push_back(int'(it.res_i));
      end
   endtask

   // Drain, let the block settle, then write min_separation while idle.
   task automatic write_min_sep(logic [cmcs_pkg::SepWidth-1:0] value);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      csr_wr_data = value;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.min_sep = value;
      sep_settings++;
   endtask

   function automatic pair_req_type random_beat();
      int roll;
      int i;
      int j;
      logic [cmcs_pkg::ProbWidth-1:0] p;
      roll = $urandom_range(0, 99);
      // Probabilities around the half point, the ends, and raw noise.
      case ($urandom_range(0, 3))
         0: p = cmcs_pkg::ProbWidth'($urandom_range(120, 136));
         1: p = $urandom_range(0, 1) ? 9'd0 : 9'd256;
         default: p = cmcs_pkg::ProbWidth'($urandom());
      endcase
      if (roll < 25) begin
         i = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 63))
                                        : int'($urandom_range(0, 1023));
         return make_load(i, 1'($urandom()), rand_coord($urandom_range(0, 9) == 0),
                          rand_coord($urandom_range(0, 9) == 0),
                          rand_coord($urandom_range(0, 9) == 0));
      end
      if (roll < 88) begin
         i = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
         j = i + int'(sb.min_sep) + int'($urandom_range(0, 4)) - 2;
         if ($urandom_range(0, 2) == 0 || j < 0 || j >= cmcs_pkg::MaxResidues || !loaded[j])
            j = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
         return make_other(cmcs_pkg::OP_PAIR, i, j, p);
      end
      if (roll < 95)
         return make_other(cmcs_pkg::OP_CLEAR, int'($urandom()), int'($urandom()),
                           cmcs_pkg::ProbWidth'($urandom()));
      return make_other(cmcs_pkg::OP_NONE, int'($urandom()), int'($urandom()),
                        cmcs_pkg::ProbWidth'($urandom()));
   endfunction

   initial begin
      logic signed [cmcs_pkg::CoordWidth-1:0] hi_c;
      logic signed [cmcs_pkg::CoordWidth-1:0] lo_c;
      sb = new();
      hold_asked = 0;
      idle_pct = 0;
      stall_pct = 0;
      sep_settings = 1;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_op = cmcs_pkg::OP_NONE;
      req_residue_index = '0;
      req_other_index = '0;
      req_is_glycine = 1'b0;
      req_ca_x = '0; req_ca_y = '0; req_ca_z = '0;
      req_cb_x = '0; req_cb_y = '0; req_cb_z = '0;
      req_contact_prob = '0;
      hi_c = {1'b0, {(cmcs_pkg::CoordWidth-1){1'b1}}};
      lo_c = {1'b1, {(cmcs_pkg::CoordWidth-1){1'b0}}};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: coordinate extremes, exact contact threshold, probability
      // ends and the half point, j below i, i equal j, clear and unused op.
      send(make_load(0, 1'b1, hi_c, hi_c, hi_c));
      send(make_load(1023, 1'b0, lo_c, lo_c, lo_c));
      send(make_load(5, 1'b0, 18'sd0, 18'sd0, 18'sd0));
      send(make_load(11, 1'b1, 18'sd512, 18'sd0, 18'sd0));     // exactly 8 A from 5
      send(make_load(12, 1'b0, 18'sd0, -18'sd513, 18'sd0));    // just past 8 A from 5
      send(make_load(20, 1'b1, 18'sd100, -18'sd200, 18'sd300));
      send(make_other(cmcs_pkg::OP_PAIR, 0, 1023, 9'd0));  // largest distance
      send(make_other(cmcs_pkg::OP_PAIR, 5, 11, 9'd0));    // at threshold, mismatch
      send(make_other(cmcs_pkg::OP_PAIR, 5, 11, 9'd128));
      send(make_other(cmcs_pkg::OP_PAIR, 5, 12, 9'd129));  // no contact, wants contact
      send(make_other(cmcs_pkg::OP_PAIR, 5, 12, 9'd256));
      send(make_other(cmcs_pkg::OP_PAIR, 5, 12, 9'd511));  // weight beyond 1.0
      send(make_other(cmcs_pkg::OP_PAIR, 12, 5, 9'd511));  // j below i
      send(make_other(cmcs_pkg::OP_PAIR, 20, 20, 9'd300)); // zero distance
      send(make_other(cmcs_pkg::OP_PAIR, 5, 10 + 1, 9'd200));
      send(make_other(cmcs_pkg::OP_NONE, 5, 12, 9'd511));  // ignored
      send(make_other(cmcs_pkg::OP_CLEAR, 0, 0, 9'd0));
      send(make_other(cmcs_pkg::OP_PAIR, 0, 1023, 9'd511));
      write_min_sep(10'd0);
      send(make_other(cmcs_pkg::OP_PAIR, 5, 5, 9'd0));
      send(make_other(cmcs_pkg::OP_PAIR, 12, 5, 9'd0));
      write_min_sep(10'd1023);
      send(make_other(cmcs_pkg::OP_PAIR, 0, 1023, 9'd0));  // separation exactly max
      send(make_other(cmcs_pkg::OP_PAIR, 5, 12, 9'd256));

      // Random: 13 segments cycle through the idling phases; the separation
      // changes between some of them, extremes included.
      for (int seg = 0; seg < 13; seg++) begin
         if (seg % 3 == 0)
            case (seg / 3)
               0: write_min_sep(cmcs_pkg::MinSepReset);
               1: write_min_sep(10'd1);
               2: write_min_sep(10'd0);
               3: write_min_sep(10'd1023);
               default: write_min_sep(cmcs_pkg::SepWidth'($urandom_range(2, 40)));
            endcase
         case (seg % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         for (int n = 0; n < 100; n++) begin
            if (seg == 4 && n == 10) hold_asked++;
            send(random_beat());
         end
      end
      req_valid = 1'b0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("Covered %0d request beats, %0d pairs, %0d penalized pairs,",
               req_beats, sb.pairs_scored, sb.penalties_seen);
      $display("%0d separation settings, %0d result beats checked",
               sep_settings, sb.results_seen);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
